// File: design/prescaled_reload_timer_with_free_run_macros.svh
// Assertion macros for the timer design files; used by prt_core.
// Included by modules that carry concurrent assertions; depends on nothing.
`ifndef PRESCALED_RELOAD_TIMER_WITH_FREE_RUN_MACROS_SVH
`define PRESCALED_RELOAD_TIMER_WITH_FREE_RUN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/prt_pkg.sv
// Shared types, register codes and constants of the prescaled reload timer.
// Used by the channel interfaces, the core and the top level; no dependencies.
package prt_pkg;

    localparam int COUNT_BITS_DEFAULT  = 32;
    localparam int PREDIV_BITS_DEFAULT = 10;

    localparam int DATA_BITS = 32;
    localparam int CTRL_BITS = 24;

    localparam logic [7:0]           FREE_PRESCALE_RESET = 8'h3E;
    localparam logic [CTRL_BITS-1:0] CTRL_RESET = {FREE_PRESCALE_RESET, 16'h0000};

    // Control register bit positions.
    localparam int CTRL_WIDE_BIT     = 1;
    localparam int CTRL_PRESCALE_LSB = 2;
    localparam int CTRL_IRQ_EN_BIT   = 5;
    localparam int CTRL_ENABLE_BIT   = 7;
    localparam int CTRL_DBG_HALT_BIT = 8;
    localparam int CTRL_FREE_EN_BIT  = 9;
    localparam int CTRL_FREE_PS_LSB  = 16;

    // Prescale selector codes; the remaining codes divide by one.
    localparam logic [1:0] PRESCALE_DIV16  = 2'd1;
    localparam logic [1:0] PRESCALE_DIV256 = 2'd2;

    localparam logic [7:0] PRESCALE_TOP_DIV1   = 8'd0;
    localparam logic [7:0] PRESCALE_TOP_DIV16  = 8'd15;
    localparam logic [7:0] PRESCALE_TOP_DIV256 = 8'd255;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } func_t;

    // Register map.
    localparam logic [2:0] REG_LOAD      = 3'd0;
    localparam logic [2:0] REG_VALUE     = 3'd1;
    localparam logic [2:0] REG_CTRL      = 3'd2;
    localparam logic [2:0] REG_IRQ_CLEAR = 3'd3;
    localparam logic [2:0] REG_RAW_IRQ   = 3'd4;
    localparam logic [2:0] REG_MASK_IRQ  = 3'd5;
    localparam logic [2:0] REG_PREDIV    = 3'd6;
    localparam logic [2:0] REG_FREECOUNT = 3'd7;

    typedef struct packed {
        logic [1:0]           func;
        logic [2:0]           reg_index;
        logic [DATA_BITS-1:0] write_data;
        logic                 debug_halted;
    } item_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] read_data;
        logic                 irq_line;
    } result_t;

endpackage

// File: design/prt_if.sv
// Valid/ready channel interfaces for the timer's command and response beats.
// Depends on prt_pkg for the data width.
interface prt_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic [2:0]                     reg_index;
    logic [prt_pkg::DATA_BITS-1:0]  write_data;
    logic                           debug_halted;

    modport source (output valid, output func, output reg_index, output write_data,
                    output debug_halted, input ready);
    modport sink   (input valid, input func, input reg_index, input write_data,
                    input debug_halted, output ready);
endinterface

interface prt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [prt_pkg::DATA_BITS-1:0]  read_data;
    logic                           irq_line;

    modport source (output valid, output read_data, output irq_line, input ready);
    modport sink   (input valid, input read_data, input irq_line, output ready);
endinterface

// File: design/prt_core.sv
// Timer state registers and the single-pass update for one command beat.
// Depends on prt_pkg and the assertion macros header.
`include "prescaled_reload_timer_with_free_run_macros.svh"

module prt_core #(
    parameter int COUNT_BITS  = prt_pkg::COUNT_BITS_DEFAULT,
    parameter int PREDIV_BITS = prt_pkg::PREDIV_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            exec,
    input  prt_pkg::item_t  item,
    output prt_pkg::result_t result
);

    localparam logic [COUNT_BITS-1:0] MASK16 = COUNT_BITS'(17'h0FFFF);

    logic [prt_pkg::DATA_BITS-1:0] load_reg, load_next;
    logic [COUNT_BITS-1:0]         down_count_reg, down_count_next;
    logic [prt_pkg::CTRL_BITS-1:0] ctrl_reg, ctrl_next;
    logic                          raw_irq_reg, raw_irq_next;
    logic [PREDIV_BITS-1:0]        prediv_limit_reg, prediv_limit_next;
    logic [PREDIV_BITS-1:0]        prediv_count_reg, prediv_count_next;
    logic [7:0]                    prescale_count_reg, prescale_count_next;
    logic [7:0]                    free_ps_count_reg, free_ps_count_next;
    logic [prt_pkg::DATA_BITS-1:0] free_count_reg, free_count_next;

    logic [COUNT_BITS-1:0] count_mask;
    logic [COUNT_BITS-1:0] count_masked;
    logic [COUNT_BITS-1:0] count_dec;
    logic [7:0]            prescale_top;
    logic [7:0]            free_top;
    logic                  frozen;
    logic                  is_tick;
    logic                  is_write;
    logic [prt_pkg::DATA_BITS-1:0] read_value;

    assign count_mask   = ctrl_reg[prt_pkg::CTRL_WIDE_BIT] ? '1 : MASK16;
    assign count_masked = down_count_reg & count_mask;
    assign count_dec    = count_masked - 1'b1;
    assign free_top     = ctrl_reg[prt_pkg::CTRL_FREE_PS_LSB +: 8];
    assign frozen       = item.debug_halted & ctrl_reg[prt_pkg::CTRL_DBG_HALT_BIT];
    assign is_tick      = exec && (item.func == prt_pkg::FUNC_TICK);
    assign is_write     = exec && (item.func == prt_pkg::FUNC_WRITE);

    always_comb
    begin
        case (ctrl_reg[prt_pkg::CTRL_PRESCALE_LSB +: 2])
            prt_pkg::PRESCALE_DIV16:  prescale_top = prt_pkg::PRESCALE_TOP_DIV16;
            prt_pkg::PRESCALE_DIV256: prescale_top = prt_pkg::PRESCALE_TOP_DIV256;
            default:                  prescale_top = prt_pkg::PRESCALE_TOP_DIV1;
        endcase
    end

    always_comb
    begin
        load_next           = load_reg;
        down_count_next     = down_count_reg;
        ctrl_next           = ctrl_reg;
        raw_irq_next        = raw_irq_reg;
        prediv_limit_next   = prediv_limit_reg;
        prediv_count_next   = prediv_count_reg;
        prescale_count_next = prescale_count_reg;
        free_ps_count_next  = free_ps_count_reg;
        free_count_next     = free_count_reg;

        if (is_tick && !frozen)
        begin
            if (ctrl_reg[prt_pkg::CTRL_ENABLE_BIT])
            begin
                // A lowered limit still fires once the count has reached or passed it.
                if (prediv_count_reg >= prediv_limit_reg)
                begin
                    prediv_count_next = '0;
                    if (prescale_count_reg >= prescale_top)
                    begin
                        prescale_count_next = '0;
                        if (count_masked == '0)
                        begin
                            down_count_next = load_reg[COUNT_BITS-1:0] & count_mask;
                        end
                        else
                        begin
                            down_count_next = count_dec;
                            if (count_dec == '0)
                            begin
                                raw_irq_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        prescale_count_next = prescale_count_reg + 8'd1;
                    end
                end
                else
                begin
                    prediv_count_next = prediv_count_reg + 1'b1;
                end
            end
            if (ctrl_reg[prt_pkg::CTRL_FREE_EN_BIT])
            begin
                if (free_ps_count_reg >= free_top)
                begin
                    free_ps_count_next = '0;
                    free_count_next    = free_count_reg + 1'b1;
                end
                else
                begin
                    free_ps_count_next = free_ps_count_reg + 8'd1;
                end
            end
        end

        if (is_write)
        begin
            case (item.reg_index)
                prt_pkg::REG_LOAD:
                begin
                    load_next       = item.write_data;
                    down_count_next = item.write_data[COUNT_BITS-1:0] & count_mask;
                end
                prt_pkg::REG_CTRL:      ctrl_next = item.write_data[prt_pkg::CTRL_BITS-1:0];
                prt_pkg::REG_IRQ_CLEAR: raw_irq_next = 1'b0;
                prt_pkg::REG_PREDIV:    prediv_limit_next = item.write_data[PREDIV_BITS-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (item.reg_index)
            prt_pkg::REG_LOAD:      read_value = load_reg;
            prt_pkg::REG_VALUE:     read_value = prt_pkg::DATA_BITS'(down_count_reg);
            prt_pkg::REG_CTRL:      read_value = prt_pkg::DATA_BITS'(ctrl_reg);
            prt_pkg::REG_RAW_IRQ:   read_value = prt_pkg::DATA_BITS'(raw_irq_reg);
            prt_pkg::REG_MASK_IRQ:
                read_value = prt_pkg::DATA_BITS'(raw_irq_reg & ctrl_reg[prt_pkg::CTRL_IRQ_EN_BIT]);
            prt_pkg::REG_PREDIV:    read_value = prt_pkg::DATA_BITS'(prediv_limit_reg);
            prt_pkg::REG_FREECOUNT: read_value = free_count_reg;
            default:                read_value = '0;
        endcase
    end

    assign result.read_data = (item.func == prt_pkg::FUNC_READ) ? read_value : '0;
    assign result.irq_line  = raw_irq_next & ctrl_next[prt_pkg::CTRL_IRQ_EN_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg           <= '0;
            down_count_reg     <= '0;
            ctrl_reg           <= prt_pkg::CTRL_RESET;
            raw_irq_reg        <= 1'b0;
            prediv_limit_reg   <= '0;
            prediv_count_reg   <= '0;
            prescale_count_reg <= '0;
            free_ps_count_reg  <= '0;
            free_count_reg     <= '0;
        end
        else if (exec)
        begin
            load_reg           <= load_next;
            down_count_reg     <= down_count_next;
            ctrl_reg           <= ctrl_next;
            raw_irq_reg        <= raw_irq_next;
            prediv_limit_reg   <= prediv_limit_next;
            prediv_count_reg   <= prediv_count_next;
            prescale_count_reg <= prescale_count_next;
            free_ps_count_reg  <= free_ps_count_next;
            free_count_reg     <= free_count_next;
        end
    end

    // The raw interrupt is only ever set by a counter step.
    `PRT_ASSERT_NOW(a_irq_set_by_tick, clk, rst_n, $rose(raw_irq_reg),
        $past(is_tick), "raw interrupt set without a tick")
    // A write to the clear register always leaves the raw interrupt low.
    `PRT_ASSERT_NEXT(a_irq_clear, clk, rst_n,
        is_write && (item.reg_index == prt_pkg::REG_IRQ_CLEAR),
        !raw_irq_reg, "raw interrupt not cleared")
    // A tick with the timer disabled never moves the down counter.
    `PRT_ASSERT_NEXT(a_disabled_hold, clk, rst_n,
        is_tick && !ctrl_reg[prt_pkg::CTRL_ENABLE_BIT],
        $stable(down_count_reg) && $stable(prescale_count_reg),
        "down counter moved while disabled")

endmodule

// File: design/prescaled_reload_timer_with_free_run.sv
// Prescaled reload timer with a free-running counter.
// Each command beat on cmd is a clock tick (func 0), a register read (func 1) or a
// register write (func 2, data in write_data); debug_halted matters on ticks only.
// Every command beat yields exactly one response beat on rsp with read_data (zero
// unless the beat was a read) and irq_line, the masked interrupt after that beat.
// A beat passes an input register, then the state update and result selection,
// then the response register, which takes it once it is empty or rsp is ready;
// rsp valid rises when the response register is loaded. One beat is taken every
// cycle while rsp is drained.
// The rate is set by the state update in prt_core, which sees each beat's effect
// before the next one executes.
// When rsp stalls, the response register holds its beat and the input register
// holds one more; cmd ready drops only when both are full and rsp is not ready.
// Reset clears all timer state, sets the free-run prescale field of ctrl to 0x3E,
// and empties both pipeline registers.
// Depends on prt_pkg, prt_if and prt_core.
module prescaled_reload_timer_with_free_run #(
    parameter int COUNT_BITS  = prt_pkg::COUNT_BITS_DEFAULT,
    parameter int PREDIV_BITS = prt_pkg::PREDIV_BITS_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    prt_cmd_if.sink cmd,
    prt_rsp_if.source rsp
);

    logic              in_valid_reg;
    prt_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    prt_pkg::result_t  out_result_reg;
    prt_pkg::result_t  core_result;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_item_reg.func         <= cmd.func;
            in_item_reg.reg_index    <= cmd.reg_index;
            in_item_reg.write_data   <= cmd.write_data;
            in_item_reg.debug_halted <= cmd.debug_halted;
        end
    end

    prt_core #(
        .COUNT_BITS  (COUNT_BITS),
        .PREDIV_BITS (PREDIV_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (advance),
        .item   (in_item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_result_reg.read_data;
    assign rsp.irq_line  = out_result_reg.irq_line;

endmodule
